@@ hdl/bfta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_pkg
// Shared types, codes and defaults for the best-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package bfta_pkg;

	localparam int HEAP_BYTES_DEF  = 65536;
	localparam int CHUNK_BYTES_DEF = 4096;
	localparam int FIRST_BLOCK     = 12;
	localparam int TAG_W           = 32;
	localparam int PROLOGUE_TAG    = 9;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_OOM     = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef struct packed {
		logic        action;
		logic [16:0] request_bytes;
		logic [15:0] release_address;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] payload_address;
		logic [16:0] granted_bytes;
	} rsp_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_WRD, S_WALK, S_EXT, S_WEPI, S_RPREV, S_RNEXT, S_MERGE,
		S_WFH, S_WFF, S_PH, S_PF, S_PSH, S_PSF,
		S_D_GRANT, S_D_OOM, S_D_IGN, S_D_FREED
	} fsm_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_INIT, OP_LOAD, OP_WRD, OP_WALK, OP_EXT, OP_WEPI, OP_RPREV,
		OP_RNEXT, OP_MERGE, OP_WFH, OP_WFF, OP_PH, OP_PF, OP_PSH, OP_PSF,
		OP_OUT_GRANT, OP_OUT_OOM, OP_OUT_IGN, OP_OUT_FREED
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic in_null;
		logic is_rel;
		logic h_lt_brk;
		logic s_zero;
		logic w_used;
		logic rel_eq;
		logic rel_gt;
		logic found;
		logic ext_more;
		logic ext_oom;
		logic rem_small;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/best_fit_boundary_tag_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_boundary_tag_allocator
// Best-fit heap allocator over a boundary-tag word memory.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | action, request_bytes, release_address
//   rsp     | out | rsp_valid/rsp_stall  | status, payload_address, granted_bytes
//
// One item at a time. Allocate: accept, then a header read and a walk step per block
// including the closing epilogue read, then place a whole block or split it, then reply.
// A miss adds chunk sizing steps, then writes the epilogue, reads both neighbours and merges.
// Release: walk up to the target, read both neighbours, merge, write the free tags; null is ignored.
// After reset, the init writes lay down prologue, first block and epilogue.
// A waiting reply does not block intake; a new reply waits for the old one.
// ----------------------------------------------------------------------------
module best_fit_boundary_tag_allocator #(
	parameter int HEAP_BYTES  = bfta_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = bfta_pkg::CHUNK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bfta_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bfta_pkg::rsp_t rsp
);

	bfta_pkg::cmd_t cmd;
	bfta_pkg::sts_t sts;

	bfta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfta_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ hdl/bfta_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfta_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bfta_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_ctrl
// Sequencer: heap init, block walk, extension, coalesce, place and reply.
// ----------------------------------------------------------------------------
module bfta_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bfta_pkg::sts_t sts,
	output bfta_pkg::cmd_t cmd
);

	bfta_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfta_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfta_pkg::S_INIT: begin
				if (sts.init_last) state_d = bfta_pkg::S_IDLE;
			end
			bfta_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sts.in_null ? bfta_pkg::S_D_IGN : bfta_pkg::S_WRD;
				end
			end
			bfta_pkg::S_WRD: begin
				if (sts.h_lt_brk) state_d = bfta_pkg::S_WALK;
				else if (sts.is_rel) state_d = bfta_pkg::S_D_IGN;
				else if (sts.found) state_d = bfta_pkg::S_PH;
				else state_d = bfta_pkg::S_EXT;
			end
			bfta_pkg::S_WALK: begin
				if (sts.is_rel) begin
					if (sts.s_zero || sts.rel_gt) state_d = bfta_pkg::S_D_IGN;
					else if (sts.rel_eq) begin
						state_d = sts.w_used ? bfta_pkg::S_RPREV : bfta_pkg::S_D_IGN;
					end else state_d = bfta_pkg::S_WRD;
				end else if (sts.s_zero) begin
					state_d = sts.found ? bfta_pkg::S_PH : bfta_pkg::S_EXT;
				end else begin
					state_d = bfta_pkg::S_WRD;
				end
			end
			bfta_pkg::S_EXT: begin
				if (!sts.ext_more) begin
					state_d = sts.ext_oom ? bfta_pkg::S_D_OOM : bfta_pkg::S_WEPI;
				end
			end
			bfta_pkg::S_WEPI:  state_d = bfta_pkg::S_RPREV;
			bfta_pkg::S_RPREV: state_d = bfta_pkg::S_RNEXT;
			bfta_pkg::S_RNEXT: state_d = bfta_pkg::S_MERGE;
			bfta_pkg::S_MERGE: state_d = sts.is_rel ? bfta_pkg::S_WFH : bfta_pkg::S_PH;
			bfta_pkg::S_WFH:   state_d = bfta_pkg::S_WFF;
			bfta_pkg::S_WFF:   state_d = bfta_pkg::S_D_FREED;
			bfta_pkg::S_PH:    state_d = bfta_pkg::S_PF;
			bfta_pkg::S_PF:    state_d = sts.rem_small ? bfta_pkg::S_D_GRANT : bfta_pkg::S_PSH;
			bfta_pkg::S_PSH:   state_d = bfta_pkg::S_PSF;
			bfta_pkg::S_PSF:   state_d = bfta_pkg::S_D_GRANT;
			bfta_pkg::S_D_GRANT, bfta_pkg::S_D_OOM, bfta_pkg::S_D_IGN,
			bfta_pkg::S_D_FREED: begin
				if (sts.out_free) state_d = bfta_pkg::S_IDLE;
			end
			default: state_d = bfta_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = bfta_pkg::OP_NONE;
		req_stall = 1'b1;
		unique case (state_q)
			bfta_pkg::S_INIT: cmd.op = bfta_pkg::OP_INIT;
			bfta_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) cmd.op = bfta_pkg::OP_LOAD;
			end
			bfta_pkg::S_WRD:   cmd.op = bfta_pkg::OP_WRD;
			bfta_pkg::S_WALK:  cmd.op = bfta_pkg::OP_WALK;
			bfta_pkg::S_EXT: begin
				if (sts.ext_more) cmd.op = bfta_pkg::OP_EXT;
			end
			bfta_pkg::S_WEPI:  cmd.op = bfta_pkg::OP_WEPI;
			bfta_pkg::S_RPREV: cmd.op = bfta_pkg::OP_RPREV;
			bfta_pkg::S_RNEXT: cmd.op = bfta_pkg::OP_RNEXT;
			bfta_pkg::S_MERGE: cmd.op = bfta_pkg::OP_MERGE;
			bfta_pkg::S_WFH:   cmd.op = bfta_pkg::OP_WFH;
			bfta_pkg::S_WFF:   cmd.op = bfta_pkg::OP_WFF;
			bfta_pkg::S_PH:    cmd.op = bfta_pkg::OP_PH;
			bfta_pkg::S_PF:    cmd.op = bfta_pkg::OP_PF;
			bfta_pkg::S_PSH:   cmd.op = bfta_pkg::OP_PSH;
			bfta_pkg::S_PSF:   cmd.op = bfta_pkg::OP_PSF;
			bfta_pkg::S_D_GRANT: begin
				if (sts.out_free) cmd.op = bfta_pkg::OP_OUT_GRANT;
			end
			bfta_pkg::S_D_OOM: begin
				if (sts.out_free) cmd.op = bfta_pkg::OP_OUT_OOM;
			end
			bfta_pkg::S_D_IGN: begin
				if (sts.out_free) cmd.op = bfta_pkg::OP_OUT_IGN;
			end
			bfta_pkg::S_D_FREED: begin
				if (sts.out_free) cmd.op = bfta_pkg::OP_OUT_FREED;
			end
			default: cmd.op = bfta_pkg::OP_NONE;
		endcase
	end

endmodule

@@ hdl/bfta_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_dp
// Datapath: tag memory, walk pointer, best-fit target, break and reply reg.
// ----------------------------------------------------------------------------
module bfta_dp #(
	parameter int HEAP_BYTES  = bfta_pkg::HEAP_BYTES_DEF,
	parameter int CHUNK_BYTES = bfta_pkg::CHUNK_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bfta_pkg::req_t req,
	input  logic           rsp_stall,
	output logic           rsp_valid,
	output bfta_pkg::rsp_t rsp,
	input  bfta_pkg::cmd_t cmd,
	output bfta_pkg::sts_t sts
);

	localparam int AW    = $clog2(HEAP_BYTES + 1);
	localparam int SW    = (AW + 1 > 19) ? AW + 1 : 19;
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int WAW   = $clog2(DEPTH);

	typedef logic [SW-1:0] off_t;

	localparam off_t CHUNK = off_t'(CHUNK_BYTES);
	localparam off_t HEAP  = off_t'(HEAP_BYTES);
	localparam off_t FIRST = off_t'(bfta_pkg::FIRST_BLOCK);

	logic                    act_q;
	off_t                    need_q, h_q, tgt_q, tsz_q, ext_q, brk_q;
	logic [15:0]             rel_q;
	logic                    found_q;
	logic [bfta_pkg::TAG_W-1:0] prev_q;
	logic [2:0]              init_q;
	logic                    rsp_valid_q;
	bfta_pkg::rsp_t          rsp_q;

	logic                       we;
	off_t                       waddr_b, raddr_b;
	logic [bfta_pkg::TAG_W-1:0] wdata, rdata;

	off_t s, psz, nsz, need_in, gsz, rem, lim, rel_x;
	logic fits;

	bfta_ram #(.WIDTH(bfta_pkg::TAG_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_b[2 +: WAW]),
		.wdata (wdata),
		.raddr (raddr_b[2 +: WAW]),
		.rdata (rdata)
	);

	assign s       = {rdata[SW-1:3], 3'b000};
	assign psz     = {prev_q[SW-1:3], 3'b000};
	assign nsz     = s;
	assign need_in = (off_t'(req.request_bytes) + off_t'(15)) & ~off_t'(7);
	assign rem     = tsz_q - need_q;
	assign gsz     = sts.rem_small ? tsz_q : need_q;
	assign lim     = HEAP - brk_q;
	assign rel_x   = off_t'(rel_q);
	assign fits    = !rdata[0] && (s >= need_q) && (!found_q || s < tsz_q);

	always_comb begin
		sts.init_last = (init_q == 3'd4);
		sts.in_null   = (req.action == bfta_pkg::ACT_RELEASE) && (req.release_address == '0);
		sts.is_rel    = (act_q == bfta_pkg::ACT_RELEASE);
		sts.h_lt_brk  = (h_q < brk_q);
		sts.s_zero    = (s == '0);
		sts.w_used    = rdata[0];
		sts.rel_eq    = (h_q + off_t'(4) == rel_x);
		sts.rel_gt    = (h_q + off_t'(4) > rel_x);
		sts.found     = found_q;
		sts.ext_more  = (ext_q <= need_q) && (ext_q <= lim);
		sts.ext_oom   = (ext_q > lim);
		sts.rem_small = (rem <= off_t'(8));
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// memory port selection
	always_comb begin
		we      = 1'b0;
		waddr_b = tgt_q;
		wdata   = '0;
		raddr_b = h_q;
		unique case (cmd.op)
			bfta_pkg::OP_INIT: begin
				we = 1'b1;
				case (init_q)
					3'd0: begin
						waddr_b = off_t'(4);
						wdata   = bfta_pkg::TAG_W'(bfta_pkg::PROLOGUE_TAG);
					end
					3'd1: begin
						waddr_b = off_t'(8);
						wdata   = bfta_pkg::TAG_W'(bfta_pkg::PROLOGUE_TAG);
					end
					3'd2: begin
						waddr_b = FIRST;
						wdata   = bfta_pkg::TAG_W'(CHUNK);
					end
					3'd3: begin
						waddr_b = FIRST + CHUNK - off_t'(4);
						wdata   = bfta_pkg::TAG_W'(CHUNK);
					end
					default: begin
						waddr_b = FIRST + CHUNK;
						wdata   = '0;
					end
				endcase
			end
			bfta_pkg::OP_WEPI: begin
				we      = 1'b1;
				waddr_b = brk_q + ext_q - off_t'(4);
			end
			bfta_pkg::OP_RPREV: raddr_b = tgt_q - off_t'(4);
			bfta_pkg::OP_RNEXT: raddr_b = tgt_q + tsz_q;
			bfta_pkg::OP_WFH: begin
				we    = 1'b1;
				wdata = bfta_pkg::TAG_W'(tsz_q);
			end
			bfta_pkg::OP_WFF: begin
				we      = 1'b1;
				waddr_b = tgt_q + tsz_q - off_t'(4);
				wdata   = bfta_pkg::TAG_W'(tsz_q);
			end
			bfta_pkg::OP_PH: begin
				we    = 1'b1;
				wdata = bfta_pkg::TAG_W'(gsz) | bfta_pkg::TAG_W'(1);
			end
			bfta_pkg::OP_PF: begin
				we      = 1'b1;
				waddr_b = tgt_q + gsz - off_t'(4);
				wdata   = bfta_pkg::TAG_W'(gsz) | bfta_pkg::TAG_W'(1);
			end
			bfta_pkg::OP_PSH: begin
				we      = 1'b1;
				waddr_b = tgt_q + need_q;
				wdata   = bfta_pkg::TAG_W'(rem);
			end
			bfta_pkg::OP_PSF: begin
				we      = 1'b1;
				waddr_b = tgt_q + tsz_q - off_t'(4);
				wdata   = bfta_pkg::TAG_W'(rem);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			brk_q       <= FIRST + CHUNK + off_t'(4);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == bfta_pkg::OP_INIT) init_q <= init_q + 3'd1;
			if (cmd.op == bfta_pkg::OP_WEPI) brk_q <= brk_q + ext_q;
			if (cmd.op == bfta_pkg::OP_OUT_GRANT || cmd.op == bfta_pkg::OP_OUT_OOM ||
			    cmd.op == bfta_pkg::OP_OUT_IGN || cmd.op == bfta_pkg::OP_OUT_FREED) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bfta_pkg::OP_LOAD: begin
				act_q   <= req.action;
				need_q  <= need_in;
				rel_q   <= req.release_address;
				h_q     <= FIRST;
				found_q <= 1'b0;
				ext_q   <= CHUNK;
			end
			bfta_pkg::OP_WALK: begin
				h_q <= h_q + s;
				if (act_q == bfta_pkg::ACT_RELEASE) begin
					if (sts.rel_eq) begin
						tgt_q <= h_q;
						tsz_q <= s;
					end
				end else if (fits) begin
					tgt_q   <= h_q;
					tsz_q   <= s;
					found_q <= 1'b1;
				end
			end
			bfta_pkg::OP_EXT: ext_q <= ext_q + CHUNK;
			bfta_pkg::OP_WEPI: begin
				tgt_q <= brk_q - off_t'(4);
				tsz_q <= ext_q;
			end
			bfta_pkg::OP_RNEXT: prev_q <= rdata;
			bfta_pkg::OP_MERGE: begin
				// rdata holds the next header here
				if (!prev_q[0]) tgt_q <= tgt_q - psz;
				tsz_q <= tsz_q + (prev_q[0] ? '0 : psz)
				       + ((rdata != '0 && !rdata[0]) ? nsz : '0);
			end
			bfta_pkg::OP_OUT_GRANT: begin
				rsp_q.status          <= bfta_pkg::ST_DONE;
				rsp_q.payload_address <= 16'(tgt_q + off_t'(4));
				rsp_q.granted_bytes   <= 17'(gsz);
			end
			bfta_pkg::OP_OUT_OOM: begin
				rsp_q.status          <= bfta_pkg::ST_OOM;
				rsp_q.payload_address <= '0;
				rsp_q.granted_bytes   <= '0;
			end
			bfta_pkg::OP_OUT_IGN: begin
				rsp_q.status          <= bfta_pkg::ST_IGNORED;
				rsp_q.payload_address <= '0;
				rsp_q.granted_bytes   <= '0;
			end
			bfta_pkg::OP_OUT_FREED: begin
				rsp_q.status          <= bfta_pkg::ST_DONE;
				rsp_q.payload_address <= '0;
				rsp_q.granted_bytes   <= '0;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_brk_limit: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q <= HEAP)
		else $error("break beyond heap");

	a_brk_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> brk_q >= $past(brk_q))
		else $error("break moved down");

	a_place_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bfta_pkg::OP_PH |-> tsz_q >= need_q && tgt_q[2:0] == 3'd4)
		else $error("placing into a bad block");

	a_ext_cover: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bfta_pkg::OP_WEPI |-> ext_q > need_q)
		else $error("extension smaller than request");

endmodule

@@ test/tb_best_fit_boundary_tag_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_boundary_tag_allocator
// Drives allocate and release items into the best-fit allocator and checks
// every reply against an in-bench model of the tag heap, under random idling
// and backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_best_fit_boundary_tag_allocator;

	localparam int HEAP  = bfta_pkg::HEAP_BYTES_DEF;
	localparam int CHUNK = bfta_pkg::CHUNK_BYTES_DEF;
	localparam int WORDS = HEAP / 4;
	localparam logic [31:0] SZ_MASK = 32'hFFFF_FFF8;
	localparam logic [16:0] PICK_MARK = 17'h1ABCD;

	logic clk, arst_n;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall, rsp_valid;
	bfta_pkg::req_t req = '0;
	bfta_pkg::rsp_t rsp;

	best_fit_boundary_tag_allocator dut (.*);

	// heap model
	logic [31:0] heap_tag [WORDS];
	logic [31:0] brk;

	bfta_pkg::req_t pending_items[$];
	bfta_pkg::rsp_t expected_replies[$];
	int   live_blocks[$];      // payload offsets currently allocated
	int   mismatches = 0;
	int   hold_count = 0;
	int   sender_idle_pct, receiver_idle_pct;
	bit   hold_receiver;
	bit   req_taken = 1'b0;

	function automatic logic [31:0] rd(logic [31:0] a);
		return heap_tag[(a >> 2) % WORDS];
	endfunction

	task automatic wr(logic [31:0] a, logic [31:0] v);
		heap_tag[(a >> 2) % WORDS] = v;
	endtask

	task automatic set_block(logic [31:0] h, logic [31:0] sz, logic used);
		wr(h, sz | used);
		wr(h + sz - 4, sz | used);
	endtask

	task automatic coalesce(logic [31:0] h, output logic [31:0] start);
		logic [31:0] sz, total, prv, nxt;
		sz = rd(h) & SZ_MASK;
		total = sz;
		start = h;
		prv = rd(h - 4);
		nxt = rd(h + sz);
		if (!prv[0]) begin
			start = h - (prv & SZ_MASK);
			total += prv & SZ_MASK;
		end
		if (nxt != 0 && !nxt[0])
			total += nxt & SZ_MASK;
		set_block(start, total, 1'b0);
	endtask

	task automatic heap_reset();
		foreach (heap_tag[i])
			heap_tag[i] = 0;
		wr(4, bfta_pkg::PROLOGUE_TAG);
		wr(8, bfta_pkg::PROLOGUE_TAG);
		set_block(bfta_pkg::FIRST_BLOCK, CHUNK, 1'b0);
		wr(bfta_pkg::FIRST_BLOCK + CHUNK, 0);
		brk = 16 + CHUNK;
	endtask

	task automatic heap_step(bfta_pkg::req_t it, output bfta_pkg::rsp_t r);
		logic [31:0] need, best, best_sz, h, w, s, ext, bsz, st;
		logic found, hit;
		r = '0;
		r.status = bfta_pkg::ST_DONE;
		if (it.action == bfta_pkg::ACT_ALLOC) begin
			need = (32'(it.request_bytes) + 15) & SZ_MASK;
			best_sz = 32'hFFFF_FFFF;
			best = 0;
			found = 0;
			h = bfta_pkg::FIRST_BLOCK;
			while (h < brk) begin
				w = rd(h);
				s = w & SZ_MASK;
				if (s == 0)
					break;
				if (!w[0] && s >= need && s < best_sz) begin
					best_sz = s;
					best = h;
					found = 1;
				end
				h += s;
			end
			if (!found) begin
				ext = CHUNK * (need / CHUNK + 1);
				if (brk > HEAP || ext > HEAP - brk) begin
					r.status = bfta_pkg::ST_OOM;
				end else begin
					set_block(brk - 4, ext, 1'b0);
					wr(brk + ext - 4, 0);
					st = brk - 4;
					brk = brk + ext;
					coalesce(st, best);
					found = 1;
				end
			end
			if (found) begin
				bsz = rd(best) & SZ_MASK;
				if (bsz - need <= 8) begin
					set_block(best, bsz, 1'b1);
					r.granted_bytes = bsz[16:0];
				end else begin
					set_block(best, need, 1'b1);
					set_block(best + need, bsz - need, 1'b0);
					r.granted_bytes = need[16:0];
				end
				r.payload_address = 16'(best + 4);
				live_blocks.push_back(int'(best + 4));
			end
		end else if (it.release_address == 0) begin
			r.status = bfta_pkg::ST_IGNORED;
		end else begin
			hit = 0;
			h = bfta_pkg::FIRST_BLOCK;
			while (h < brk) begin
				w = rd(h);
				s = w & SZ_MASK;
				if (s == 0)
					break;
				if (h + 4 == it.release_address) begin
					hit = w[0];
					break;
				end
				if (h + 4 > it.release_address)
					break;
				h += s;
			end
			if (hit) begin
				set_block(h, rd(h) & SZ_MASK, 1'b0);
				coalesce(h, st);
				for (int i = 0; i < live_blocks.size(); i++) begin
					if (live_blocks[i] == int'(it.release_address)) begin
						live_blocks.delete(i);
						break;
					end
				end
			end else begin
				r.status = bfta_pkg::ST_IGNORED;
			end
		end
	endtask

	function automatic bfta_pkg::req_t make_alloc(int n);
		bfta_pkg::req_t it;
		it.action = bfta_pkg::ACT_ALLOC;
		it.request_bytes = 17'(n);
		it.release_address = 16'($urandom);
		return it;
	endfunction

	function automatic bfta_pkg::req_t make_release(int a);
		bfta_pkg::req_t it;
		it.action = bfta_pkg::ACT_RELEASE;
		it.request_bytes = 17'($urandom_range(0, 32'h1ABCC));
		it.release_address = 16'(a);
		return it;
	endfunction

	// releases of live blocks are picked when driven, against the accepted heap
	function automatic bfta_pkg::req_t random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if ($urandom_range(0, 9) == 0)
				return make_alloc($urandom_range(0, 17'h1FFFF));
			if ($urandom_range(0, 3) == 0)
				return make_alloc($urandom_range(0, 6000));
			return make_alloc($urandom_range(0, 300));
		end
		if (r < 85 && live_blocks.size() > 0)
			return make_release(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
		if (r < 92)
			return make_release($urandom);
		return make_release(0);
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				req_valid <= 1'b1;
				if (pending_items[0].action == bfta_pkg::ACT_RELEASE
						&& pending_items[0].request_bytes == PICK_MARK)
					req <= random_item();
				else
					req <= pending_items[0];
				void'(pending_items.pop_front());
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_receiver) begin
			rsp_stall <= 1'b1;
			hold_count++;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		bfta_pkg::rsp_t r;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			heap_step(req, r);
			expected_replies.push_back(r);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply %p", rsp);
			end else begin
				if (rsp !== expected_replies[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply mismatch: expected %p got %p",
							expected_replies[0], rsp);
				end
				void'(expected_replies.pop_front());
			end
		end
	end

	task automatic load_random(int n);
		bfta_pkg::req_t it;
		for (int i = 0; i < n; i++) begin
			// marker: pick the item when it is driven, against the live heap
			it = make_release(0);
			it.request_bytes = PICK_MARK;
			pending_items.push_back(it);
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || req_valid || expected_replies.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		sender_idle_pct = 34;
		receiver_idle_pct = 87;
		hold_receiver = 0;
		arst_n = 0;
		heap_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: zero, small, exact fits, split remainders, big, limits
		pending_items.push_back(make_alloc(0));
		pending_items.push_back(make_alloc(1));
		pending_items.push_back(make_alloc(8));
		pending_items.push_back(make_alloc(100));
		pending_items.push_back(make_release(16));
		pending_items.push_back(make_release(16));        // already free
		pending_items.push_back(make_release(0));         // null
		pending_items.push_back(make_release(8));         // prologue
		pending_items.push_back(make_release(17));        // mid block
		pending_items.push_back(make_release(16'hFFFF));  // past break
		pending_items.push_back(make_alloc(4072));        // miss, extend
		pending_items.push_back(make_alloc(65536));       // out of memory
		pending_items.push_back(make_alloc(17'h1FFFF));
		pending_items.push_back(make_alloc(20000));
		pending_items.push_back(make_alloc(30000));
		pending_items.push_back(make_release(28));
		pending_items.push_back(make_release(4));
		drain();

		load_random(400);
		drain();
		// long receiver hold while the sender keeps offering
		hold_receiver = 1;
		load_random(40);
		sender_idle_pct = 0;
		wait (hold_count >= 600);
		hold_receiver = 0;
		sender_idle_pct = 87;
		receiver_idle_pct = 34;
		drain();
		load_random(440);
		drain();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		load_random(450);
		drain();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && expected_replies.size() == 0)
			$display("best_fit_boundary_tag_allocator test passed");
		else
			$display("best_fit_boundary_tag_allocator test failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("best_fit_boundary_tag_allocator test failed");
		$finish;
	end

endmodule
